// ===== src/pcbd_pkg.sv =====
// Package for the prefix-code bit decoder: field widths, opcodes, transfer
// structs and the code-mask helper. Used by pcbd_table and prefix_code_bit_decoder.
// No dependencies.
package pcbd_pkg;

  localparam int ACC_W              = 16;  // accumulated code bits
  localparam int LEN_CMP_W          = 6;   // common width for length compares
  localparam int DEF_TABLE_ENTRIES  = 256;
  localparam int DEF_MAX_CODE_LEN   = 16;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_DECODE = 2'd1,
    OP_CLEAR  = 2'd2
  } pcbd_op_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  entry_index;
    logic [7:0]  entry_symbol;
    logic [15:0] entry_code;
    logic [4:0]  entry_length;
    logic        code_bit;
  } pcbd_in_t;

  typedef struct packed {
    logic       symbol_valid;
    logic [7:0] symbol;
    logic       code_error;
  } pcbd_out_t;

  // Table write request from the top level.
  typedef struct packed {
    logic        en;
    logic [7:0]  idx;
    logic [7:0]  symbol;
    logic [15:0] code;
    logic [4:0]  length;
  } pcbd_wr_t;

  // Only the low len bits of a code take part in a compare.
  function automatic logic [ACC_W-1:0] pcbd_len_mask(input logic [4:0] len);
    logic [ACC_W-1:0] mask;
    mask = '1;
    if (int'(len) < ACC_W) begin
      mask = ACC_W'((17'd1 << len) - 17'd1);
    end
    return mask;
  endfunction

endpackage

// ===== src/pcbd_table.sv =====
// Code table of the prefix-code bit decoder: slot storage, one compare lane per
// slot, and lowest-index symbol selection from a registered hit vector.
// Depends on pcbd_pkg.
module pcbd_table #(
  parameter int TABLE_ENTRIES = pcbd_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pcbd_pkg::pcbd_wr_t              wr,
  input  logic [pcbd_pkg::ACC_W-1:0]      key_code,
  input  logic [pcbd_pkg::LEN_CMP_W-1:0]  key_len,
  output logic [TABLE_ENTRIES-1:0]        hit,
  input  logic [TABLE_ENTRIES-1:0]        sel,
  output logic [7:0]                      sel_symbol
);
  import pcbd_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [TABLE_ENTRIES-1:0] slot_valid_r;
  logic [ACC_W-1:0]         slot_code_r   [TABLE_ENTRIES];
  logic [4:0]               slot_length_r [TABLE_ENTRIES];
  logic [7:0]               slot_symbol_r [TABLE_ENTRIES];

  logic                     wr_hit;
  logic [IDX_W-1:0]         wr_idx;
  logic [TABLE_ENTRIES-1:0] sel_first;

  assign wr_hit = wr.en && ({1'b0, wr.idx} < 9'(TABLE_ENTRIES));
  assign wr_idx = wr.idx[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (wr_hit) begin
      slot_valid_r[wr_idx] <= (wr.length != 5'd0);
    end
  end

  // Codes are stored pre-masked to their length, so a lane compares directly
  // against the accumulator, whose bits above its length are always zero.
  always_ff @(posedge clk) begin
    if (wr_hit) begin
      slot_code_r[wr_idx]   <= wr.code & pcbd_len_mask(wr.length);
      slot_length_r[wr_idx] <= wr.length;
      slot_symbol_r[wr_idx] <= wr.symbol;
    end
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_lane
    assign hit[i] = slot_valid_r[i]
                 && (LEN_CMP_W'(slot_length_r[i]) == key_len)
                 && (slot_code_r[i] == key_code);
  end

  // Isolate the lowest set bit, then an AND-OR mux picks its symbol.
  assign sel_first = sel & (~sel + TABLE_ENTRIES'(1));

  always_comb begin
    sel_symbol = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      sel_symbol = sel_symbol | (slot_symbol_r[i] & {8{sel_first[i]}});
    end
  end

endmodule

// ===== src/prefix_code_bit_decoder.sv =====
// Bit-serial prefix-code decoder. One item is taken per cycle unless in_stall is
// high. A load item writes a table slot and is seen by the very next item; a
// clear item restarts the code accumulator. A decode item shifts its bit into
// the accumulator and compares it against every slot at once; its result passes
// through the hit vector register, then the output register, where the
// lowest-index matching slot supplies the symbol. Loads and clears give no
// result. Input stalls only while a finished result is held by out_stall.
// Depends on pcbd_pkg and pcbd_table.
module prefix_code_bit_decoder #(
  parameter int TABLE_ENTRIES = pcbd_pkg::DEF_TABLE_ENTRIES,
  parameter int MAX_CODE_LEN  = pcbd_pkg::DEF_MAX_CODE_LEN
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pcbd_pkg::pcbd_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pcbd_pkg::pcbd_out_t  out_data
);
  import pcbd_pkg::*;

  localparam int ACC_LEN_W = $clog2(MAX_CODE_LEN + 1);

  logic [ACC_W-1:0]         acc_bits_r,  acc_bits_nxt;
  logic [ACC_LEN_W-1:0]     acc_len_r,   acc_len_nxt;
  logic [ACC_W-1:0]         acc_shift;
  logic [ACC_LEN_W-1:0]     acc_len_inc;

  logic                     adv;
  logic                     in_fire;
  logic                     is_decode;
  logic                     any_hit;
  logic                     overflow;
  logic [TABLE_ENTRIES-1:0] hit;
  logic [7:0]               sel_symbol;
  pcbd_wr_t                 wr;

  logic                     s1_valid_r;
  logic [TABLE_ENTRIES-1:0] s1_hit_r;
  logic                     s1_err_r;
  logic                     out_valid_r;
  pcbd_out_t                out_r;

  assign in_stall  = out_valid_r && out_stall;
  assign adv       = !in_stall;
  assign in_fire   = in_valid && !in_stall;
  assign is_decode = (in_data.opcode == OP_DECODE);

  assign wr.en     = in_fire && (in_data.opcode == OP_LOAD);
  assign wr.idx    = in_data.entry_index;
  assign wr.symbol = in_data.entry_symbol;
  assign wr.code   = in_data.entry_code;
  assign wr.length = in_data.entry_length;

  // The accumulator is cleared before it reaches MAX_CODE_LEN, so the
  // increment never wraps.
  assign acc_shift   = {acc_bits_r[ACC_W-2:0], in_data.code_bit};
  assign acc_len_inc = acc_len_r + ACC_LEN_W'(1);

  pcbd_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .key_code   (acc_shift),
    .key_len    (LEN_CMP_W'(acc_len_inc)),
    .hit        (hit),
    .sel        (s1_hit_r),
    .sel_symbol (sel_symbol)
  );

  assign any_hit  = |hit;
  assign overflow = !any_hit && (acc_len_inc == ACC_LEN_W'(MAX_CODE_LEN));

  always_comb begin
    acc_bits_nxt = acc_bits_r;
    acc_len_nxt  = acc_len_r;
    if (in_fire) begin
      unique case (in_data.opcode)
        OP_DECODE: begin
          if (any_hit || overflow) begin
            acc_bits_nxt = '0;
            acc_len_nxt  = '0;
          end else begin
            acc_bits_nxt = acc_shift;
            acc_len_nxt  = acc_len_inc;
          end
        end
        OP_CLEAR: begin
          acc_bits_nxt = '0;
          acc_len_nxt  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_bits_r  <= '0;
      acc_len_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_bits_r <= acc_bits_nxt;
      acc_len_r  <= acc_len_nxt;
      if (adv) begin
        s1_valid_r  <= in_fire && is_decode;
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Both stages move together, so a load accepted in the same cycle cannot
  // change the symbol that the output stage is selecting.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_hit_r           <= hit;
      s1_err_r           <= overflow;
      out_r.symbol_valid <= |s1_hit_r;
      out_r.symbol       <= sel_symbol;
      out_r.code_error   <= s1_err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_acc_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    acc_len_r < ACC_LEN_W'(MAX_CODE_LEN))
    else $error("accumulator length reached the maximum without clearing");

  a_acc_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(acc_len_r) < ACC_W) |-> ((acc_bits_r >> acc_len_r) == '0))
    else $error("accumulator holds bits above its length");

  a_hit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_decode && any_hit) |=> (acc_len_r == '0 && acc_bits_r == '0))
    else $error("accumulator not cleared after a match");

  a_hit_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_valid_r && (|s1_hit_r)) |=> (out_valid_r && out_r.symbol_valid))
    else $error("match lost between hit register and output");

  a_no_hit_and_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.symbol_valid && out_r.code_error))
    else $error("symbol and code error flagged together");

endmodule

// ===== verif/prefix_code_bit_decoder_tb.sv =====
// Self-checking testbench for prefix_code_bit_decoder: table loads, bit-serial decoding,
// clears and overflow, checked against a cycle-free model of the code table.
// Depends on pcbd_pkg and the prefix_code_bit_decoder RTL.
module prefix_code_bit_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcbd_pkg::*;

  localparam int N_SLOTS     = DEF_TABLE_ENTRIES;
  localparam int MAX_LEN     = DEF_MAX_CODE_LEN;
  localparam int TOTAL_ITEMS = 600;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  pcbd_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  pcbd_out_t out_data;

  // Model of the decoder's table and code accumulator.
  bit          tbl_valid [N_SLOTS];
  logic [15:0] tbl_code [N_SLOTS];
  logic [4:0]  tbl_len [N_SLOTS];
  logic [7:0]  tbl_sym [N_SLOTS];
  logic [15:0] acc_code = '0;
  int          acc_len = 0;

  pcbd_out_t expected_decodes [$];
  int        error_count = 0;
  int        items_sent = 0;
  bit        in_gaps_on = 1'b1;
  bit        out_stalls_on = 1'b1;

  prefix_code_bit_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string what);
    error_count++;
    // Keep the log short when everything goes wrong.
    if (error_count <= 100) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  task automatic predict_item(input pcbd_in_t item);
    pcbd_out_t   res;
    logic [15:0] mask;
    bit          hit;
    case (item.opcode)
      OP_LOAD: begin
        if (int'(item.entry_index) < N_SLOTS) begin
          tbl_valid[item.entry_index] = (item.entry_length != 5'd0);
          tbl_code[item.entry_index]  = item.entry_code;
          tbl_len[item.entry_index]   = item.entry_length;
          tbl_sym[item.entry_index]   = item.entry_symbol;
        end
      end
      OP_CLEAR: begin
        acc_code = '0;
        acc_len  = 0;
      end
      OP_DECODE: begin
        acc_code = {acc_code[14:0], item.code_bit};
        acc_len++;
        res = '0;
        hit = 1'b0;
        mask = (acc_len >= ACC_W) ? 16'hFFFF : 16'((32'd1 << acc_len) - 32'd1);
        // The lowest matching slot wins, so stop at the first hit.
        for (int i = 0; i < N_SLOTS && !hit; i++) begin
          if (tbl_valid[i] && int'(tbl_len[i]) == acc_len &&
              (tbl_code[i] & mask) == (acc_code & mask)) begin
            hit = 1'b1;
            res.symbol_valid = 1'b1;
            res.symbol = tbl_sym[i];
          end
        end
        if (hit) begin
          acc_code = '0;
          acc_len  = 0;
        end else if (acc_len >= MAX_LEN) begin
          res.code_error = 1'b1;
          acc_code = '0;
          acc_len  = 0;
        end
        expected_decodes = {expected_decodes, res};
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input pcbd_in_t item);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_item(item);
    if (item.opcode != OP_UNUSED) begin
      items_sent++;
    end
  endtask

  function automatic pcbd_in_t random_item(input logic [1:0] op);
    pcbd_in_t item;
    item.opcode       = op;
    item.entry_index  = 8'($urandom);
    item.entry_symbol = 8'($urandom);
    item.entry_code   = 16'($urandom);
    item.entry_length = 5'($urandom);
    item.code_bit     = 1'($urandom);
    return item;
  endfunction

  task automatic send_load(input logic [7:0] idx, input logic [7:0] sym,
                           input logic [15:0] code, input logic [4:0] len);
    pcbd_in_t item;
    item = random_item(OP_LOAD);
    item.entry_index  = idx;
    item.entry_symbol = sym;
    item.entry_code   = code;
    item.entry_length = len;
    send_item(item);
  endtask

  task automatic send_decode(input logic bit_val);
    pcbd_in_t item;
    item = random_item(OP_DECODE);
    item.code_bit = bit_val;
    send_item(item);
  endtask

  // Every decode transfer yields one result; compare it with the oldest prediction.
  always @(posedge clk) begin : result_check
    pcbd_out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_decodes.size() == 0) begin
        report_mismatch($sformatf("result %h arrived with none expected", out_data));
      end else begin
        want = expected_decodes.pop_front();
        if (out_data.symbol_valid !== want.symbol_valid) begin
          report_mismatch($sformatf("symbol_valid %b, expected %b",
                                    out_data.symbol_valid, want.symbol_valid));
        end
        if (out_data.symbol !== want.symbol) begin
          report_mismatch($sformatf("symbol %h, expected %h", out_data.symbol, want.symbol));
        end
        if (out_data.code_error !== want.code_error) begin
          report_mismatch($sformatf("code_error %b, expected %b",
                                    out_data.code_error, want.code_error));
        end
      end
    end
  end

  // Result side: hold off for a random number of cycles, then take one transfer.
  initial begin : result_stall
    int hold;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      hold = out_stalls_on ? $urandom_range(0, 17) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Duplicate codes, invalid lengths, stray code bits, the unused opcode and clear.
  task automatic test_slot_rules();
    pcbd_in_t item;
    send_load(8'd0, 8'hA5, 16'hFFFE, 5'd1);   // code "0"; upper bits are junk
    send_load(8'd7, 8'h3C, 16'h0000, 5'd1);   // same code, higher slot loses
    send_load(8'd200, 8'h11, 16'h0001, 5'd31); // longer than any code: never hits
    send_decode(1'b0);
    // An unused opcode must not act as a load that would empty slot 0.
    item = random_item(OP_UNUSED);
    item.entry_index  = 8'd0;
    item.entry_length = 5'd0;
    send_item(item);
    send_decode(1'b0);
    send_load(8'd0, 8'h00, 16'h0000, 5'd0);   // zero length empties the slot
    send_decode(1'b0);
    send_decode(1'b1);
    send_item(random_item(OP_CLEAR));
    send_decode(1'b0);
  endtask

  // A full 16-bit code must match on the last bit instead of overflowing.
  task automatic test_full_length_match();
    send_load(8'd255, 8'hFF, 16'hFFFF, 5'd16);
    repeat (MAX_LEN) send_decode(1'b1);
  endtask

  task automatic test_unmatched_overflow();
    send_load(8'd7, 8'($urandom), 16'($urandom), 5'd0);
    send_load(8'd200, 8'($urandom), 16'($urandom), 5'd0);
    send_load(8'd255, 8'($urandom), 16'($urandom), 5'd0);
    // With an empty table every sixteenth bit overflows unless a clear comes first.
    repeat (48) begin
      if ($urandom_range(0, 23) == 0) begin
        send_item(random_item(OP_CLEAR));
      end else begin
        send_decode(1'($urandom));
      end
    end
  endtask

  // Random complete prefix codes, loaded into random slots and then decoded from
  // symbol streams with some noise mixed in.
  task automatic test_random_code_streams();
    logic [15:0] leaf_code [$];
    int          leaf_len [$];
    logic [7:0]  leaf_slot [$];
    logic [7:0]  round_slots [$];
    bit          slot_taken [N_SLOTS];
    logic [15:0] c;
    int          j, n_leaves, skip, pick, noise;
    bit          deep;
    while (items_sent < TOTAL_ITEMS) begin
      in_gaps_on    = ($urandom_range(0, 3) != 0);
      out_stalls_on = ($urandom_range(0, 3) != 0);

      // Grow a code tree by splitting leaves; a deep tree reaches the maximum length.
      leaf_code = {16'd0, 16'd1};
      leaf_len  = {1, 1};
      deep = ($urandom_range(0, 5) == 0);
      n_leaves = deep ? MAX_LEN + 1 : $urandom_range(2, 20);
      while (leaf_code.size() < n_leaves) begin
        if (deep) begin
          j = leaf_code.size() - 1;
        end else begin
          do j = $urandom_range(0, leaf_code.size() - 1); while (leaf_len[j] >= MAX_LEN);
        end
        c = leaf_code[j];
        leaf_code[j] = c << 1;
        leaf_len[j]++;
        leaf_code = {leaf_code, (c << 1) | 16'd1};
        leaf_len  = {leaf_len, leaf_len[j]};
      end

      foreach (slot_taken[k]) slot_taken[k] = 1'b0;
      leaf_slot.delete();
      round_slots.delete();
      for (int k = 0; k < n_leaves; k++) begin
        do j = $urandom_range(0, N_SLOTS - 1); while (slot_taken[j]);
        slot_taken[j] = 1'b1;
        leaf_slot = {leaf_slot, 8'(j)};
      end
      // Leaving one leaf out makes its code run on until it overflows.
      skip = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_leaves - 1) : -1;
      for (int k = 0; k < n_leaves; k++) begin
        if (k != skip) begin
          send_load(leaf_slot[k], 8'($urandom),
                    leaf_code[k] | (16'($urandom) << leaf_len[k]), 5'(leaf_len[k]));
          round_slots = {round_slots, leaf_slot[k]};
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, n_leaves - 1);
        do j = $urandom_range(0, N_SLOTS - 1); while (slot_taken[j]);
        send_load(8'(j), 8'($urandom), leaf_code[pick], 5'(leaf_len[pick]));
        round_slots = {round_slots, 8'(j)};
      end

      repeat ($urandom_range(8, 25)) begin
        noise = $urandom_range(0, 19);
        case (noise)
          0: send_item(random_item(OP_CLEAR));
          1: send_item(random_item(OP_UNUSED));
          2: begin
            j = $urandom_range(0, N_SLOTS - 1);
            send_load(8'(j), 8'($urandom), 16'($urandom), 5'($urandom_range(0, 31)));
            round_slots = {round_slots, 8'(j)};
          end
          3: send_decode(1'($urandom));
          default: begin
            pick = $urandom_range(0, n_leaves - 1);
            for (int b = leaf_len[pick] - 1; b >= 0; b--) begin
              send_decode(leaf_code[pick][b]);
            end
          end
        endcase
      end

      foreach (round_slots[k]) begin
        send_load(round_slots[k], 8'($urandom), 16'($urandom), 5'd0);
      end
    end
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (expected_decodes.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (expected_decodes.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_decodes.size()));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_slot_rules();
    test_full_length_match();
    test_unmatched_overflow();
    test_random_code_streams();
    drain_results();
    if (error_count == 0) begin
      $display("** prefix_code_bit_decoder: PASSED **");
    end else begin
      $display("** prefix_code_bit_decoder: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("** prefix_code_bit_decoder: FAILED **");
    $finish;
  end

endmodule
